@@ src/wfms_pkg.sv @@
// ----------------------------------------------------------------------------
// wfms_pkg: shared constants, types and tables for the windowed spectrum block
// Holds the quarter-wave cosine table, sizes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none
package wfms_pkg;

  localparam int unsigned FftLenDefault = 128;
  localparam int unsigned SampleW = 16;
  localparam int unsigned BinW = 6;
  localparam int unsigned ValW = 22;
  localparam int unsigned HopW = 16;
  localparam int unsigned HopReset = 16;
  localparam int unsigned XwW = 16;
  localparam int unsigned AccW = 48;
  localparam logic signed [ValW-1:0] ValMax = 22'sd2097151;
  localparam logic signed [ValW-1:0] ValMin = -22'sd2097152;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WIN_RD,
    ST_WIN_MUL,
    ST_DFT_RD,
    ST_DFT_MUL,
    ST_DFT_ACC,
    ST_ROUND,
    ST_SQRT,
    ST_EMIT
  } state_t;

  function automatic logic signed [17:0] quarter_cos(input logic [5:0] q);
    logic signed [17:0] r;
    case (q)
      6'd0: r = 18'sd32768;   6'd1: r = 18'sd32729;   6'd2: r = 18'sd32610;
      6'd3: r = 18'sd32413;   6'd4: r = 18'sd32138;   6'd5: r = 18'sd31786;
      6'd6: r = 18'sd31357;   6'd7: r = 18'sd30853;   6'd8: r = 18'sd30274;
      6'd9: r = 18'sd29622;   6'd10: r = 18'sd28899;  6'd11: r = 18'sd28106;
      6'd12: r = 18'sd27245;  6'd13: r = 18'sd26319;  6'd14: r = 18'sd25330;
      6'd15: r = 18'sd24279;  6'd16: r = 18'sd23170;  6'd17: r = 18'sd22006;
      6'd18: r = 18'sd20788;  6'd19: r = 18'sd19520;  6'd20: r = 18'sd18205;
      6'd21: r = 18'sd16846;  6'd22: r = 18'sd15447;  6'd23: r = 18'sd14010;
      6'd24: r = 18'sd12540;  6'd25: r = 18'sd11039;  6'd26: r = 18'sd9512;
      6'd27: r = 18'sd7962;   6'd28: r = 18'sd6393;   6'd29: r = 18'sd4808;
      6'd30: r = 18'sd3212;   6'd31: r = 18'sd1608;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  // full-wave cosine from the quarter table, unsaturated (range +-32768)
  function automatic logic signed [17:0] cos_raw(input logic [6:0] m);
    logic signed [17:0] r;
    if (m <= 7'd32) r = quarter_cos(6'(m));
    else if (m <= 7'd64) r = -quarter_cos(6'(7'd64 - m));
    else if (m <= 7'd96) r = -quarter_cos(6'(m - 7'd64));
    else r = quarter_cos(6'(8'd128 - {1'b0, m}));
    return r;
  endfunction

  function automatic logic signed [16:0] cos_q15(input logic [6:0] m);
    logic signed [17:0] c;
    c = cos_raw(m);
    return (c > 18'sd32767) ? 17'sd32767 : 17'(c);
  endfunction

endpackage
`default_nettype wire

@@ src/wfms_ram.sv @@
// ----------------------------------------------------------------------------
// wfms_ram: generic single-port synchronous RAM
// One write or read per cycle; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module wfms_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ src/windowed_fft_magnitude_spectrum.sv @@
// ----------------------------------------------------------------------------
// windowed_fft_magnitude_spectrum: Hann-windowed magnitude spectrum
// Keeps the last FFT_LEN samples in a ring RAM; on each due frame windows the
// snapshot into a work RAM and computes bins 0..FFT_LEN/2-1 one at a time.
// ----------------------------------------------------------------------------
// channel  dir  handshake                   payload
// cfg      in   cfg_valid / cfg_ready       cfg_data (hop_period)
// in       in   in_valid / in_ready         sample
// out      out  out_valid / out_ready       bin_index, bin_value, last_bin
//
// After reset a clearing pass zeroes the ring; no sample is taken meanwhile.
// A due frame is windowed sample by sample (ring read, then multiply and
// work RAM write); then each bin runs through the shared multiply-accumulate
// (read, multiply, accumulate per sample) on the single work RAM port, a
// rounding step, a 27-step square root (clamp only for bin 0) and an emit step.
// Output stalls hold the controller in the emit state.
// ----------------------------------------------------------------------------
`default_nettype none
module windowed_fft_magnitude_spectrum
  import wfms_pkg::*;
#(
  parameter int unsigned FFT_LEN = FftLenDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [HopW-1:0]             cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [SampleW-1:0]   sample,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [BinW-1:0]                  bin_index,
  output logic signed [ValW-1:0]           bin_value,
  output logic                             last_bin
);
  localparam int unsigned AW = $clog2(FFT_LEN);
  localparam int unsigned Step = 128 / FFT_LEN;
  localparam logic [AW-1:0] LastN = AW'(FFT_LEN - 1);
  localparam logic [BinW-1:0] LastK = BinW'(FFT_LEN / 2 - 1);

  state_t state, state_next;

  logic [HopW-1:0] hop_period;
  logic [16:0]     countdown;
  logic [AW-1:0]   write_pointer;
  logic [AW-1:0]   n_cnt;
  logic [BinW-1:0] k_cnt;
  logic [4:0]      sq_cnt;

  logic            ring_we, work_we;
  logic [AW-1:0]   ring_addr, work_addr;
  logic [SampleW-1:0] ring_wdata, ring_rdata;
  logic [AccW-1:0] work_wdata, work_rdata;

  logic signed [XwW-1:0]  xw;
  logic signed [16:0]     win;
  logic signed [32:0]     prod_w;
  logic signed [16:0]     tw_c, tw_s;
  logic signed [33:0]     prod_c, prod_s;
  logic signed [AccW-1:0] acc_r, acc_i;
  logic signed [26:0]     re, im;
  logic signed [53:0]     re_sq, im_sq;
  logic [53:0]            sq_v, sq_res, sq_bit;
  logic [53:0]            sq_try, sq_res_step;
  logic                   sq_take;
  logic signed [ValW-1:0] result;
  logic [6:0]             m_idx;
  logic [6:0]             w_idx;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) hop_period <= HopW'(HopReset);
    else if (cfg_valid) hop_period <= cfg_data;
  end

  wfms_ram #(.Width(SampleW), .Depth(FFT_LEN)) u_ring (
    .clk(clk), .we(ring_we), .addr(ring_addr), .wdata(ring_wdata), .rdata(ring_rdata)
  );
  wfms_ram #(.Width(AccW), .Depth(FFT_LEN)) u_work (
    .clk(clk), .we(work_we), .addr(work_addr), .wdata(work_wdata), .rdata(work_rdata)
  );

  assign in_ready = (state == ST_IDLE);
  wire in_fire = in_valid && in_ready;
  wire frame_due = (countdown <= 17'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (n_cnt == LastN) state_next = ST_IDLE;
      ST_IDLE:    if (in_fire && frame_due) state_next = ST_WIN_RD;
      ST_WIN_RD:  state_next = ST_WIN_MUL;
      ST_WIN_MUL: state_next = (n_cnt == LastN) ? ST_DFT_RD : ST_WIN_RD;
      ST_DFT_RD:  state_next = ST_DFT_MUL;
      ST_DFT_MUL: state_next = ST_DFT_ACC;
      ST_DFT_ACC: state_next = (n_cnt == LastN) ? ST_ROUND : ST_DFT_RD;
      ST_ROUND:   state_next = ST_SQRT;
      ST_SQRT:    if (sq_cnt == 5'd0 || k_cnt == '0) state_next = ST_EMIT;
      ST_EMIT:    if (out_ready) state_next = (k_cnt == LastK) ? ST_IDLE : ST_DFT_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // memory port control
  always_comb begin
    ring_we = 1'b0;
    ring_addr = n_cnt + write_pointer;
    ring_wdata = sample;
    work_we = 1'b0;
    work_addr = n_cnt;
    work_wdata = AccW'(xw);
    unique case (state)
      ST_CLEAR: begin
        ring_we = 1'b1;
        ring_addr = n_cnt;
        ring_wdata = '0;
      end
      ST_IDLE: begin
        ring_we = in_fire;
        ring_addr = write_pointer;
      end
      ST_WIN_MUL: work_we = 1'b1;
      default: ;
    endcase
  end

  assign w_idx = 7'(n_cnt) * 7'(Step);
  assign win = 17'((18'sd32769 - cos_raw(w_idx)) >>> 1) > 17'sd32767
               ? 17'sd32767
               : 17'((18'sd32769 - cos_raw(w_idx)) >>> 1);
  assign prod_w = $signed(ring_rdata) * win;
  assign xw = XwW'((prod_w + 33'sd16384) >>> 15);

  assign m_idx = 7'(n_cnt * k_cnt * Step);
  always_ff @(posedge clk) begin
    tw_c <= cos_q15(m_idx);
    tw_s <= cos_q15(m_idx + 7'd96);
    prod_c <= $signed(work_rdata[XwW-1:0]) * tw_c;
    prod_s <= $signed(work_rdata[XwW-1:0]) * tw_s;
  end

  assign re = 27'((acc_r + 48'sd16384) >>> 15);
  assign im = 27'((acc_i + 48'sd16384) >>> 15);
  assign re_sq = re * re;
  assign im_sq = im * im;

  // one restoring square-root step
  assign sq_try = sq_res + sq_bit;
  assign sq_take = (sq_v >= sq_try);
  assign sq_res_step = sq_take ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_cnt <= '0;
      k_cnt <= '0;
      write_pointer <= '0;
      countdown <= '0;
      sq_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: n_cnt <= n_cnt + 1'b1;
        ST_IDLE: if (in_fire) begin
          write_pointer <= write_pointer + 1'b1;
          n_cnt <= '0;
          k_cnt <= '0;
          acc_r <= '0;
          acc_i <= '0;
          if (frame_due) countdown <= {1'b0, hop_period};
          else countdown <= countdown - 1'b1;
        end
        ST_WIN_MUL: n_cnt <= n_cnt + 1'b1;
        ST_DFT_ACC: begin
          n_cnt <= n_cnt + 1'b1;
          if (k_cnt == '0) acc_r <= acc_r + AccW'($signed(work_rdata[XwW-1:0]));
          else begin
            acc_r <= acc_r + AccW'(prod_c);
            acc_i <= acc_i + AccW'(prod_s);
          end
        end
        ST_ROUND: begin
          sq_v <= re_sq + im_sq;
          sq_res <= '0;
          sq_bit <= 54'd1 << 52;
          sq_cnt <= 5'd26;
        end
        ST_SQRT: begin
          if (k_cnt == '0) begin
            result <= (acc_r > 48'(ValMax)) ? ValMax
                    : (acc_r < 48'(ValMin)) ? ValMin : 22'(acc_r);
            out_valid <= 1'b1;
          end else begin
            if (sq_take) sq_v <= sq_v - sq_try;
            sq_res <= sq_res_step;
            sq_bit <= sq_bit >> 2;
            sq_cnt <= sq_cnt - 1'b1;
            if (sq_cnt == 5'd0) begin
              result <= (sq_res_step > 54'(ValMax)) ? ValMax : 22'(sq_res_step);
              out_valid <= 1'b1;
            end
          end
        end
        ST_EMIT: if (out_ready) begin
          out_valid <= 1'b0;
          k_cnt <= k_cnt + 1'b1;
          n_cnt <= '0;
          acc_r <= '0;
          acc_i <= '0;
        end
        default: ;
      endcase
    end
  end

  assign bin_index = k_cnt;
  assign bin_value = result;
  assign last_bin = (k_cnt == LastK);
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for windowed_fft_magnitude_spectrum
// Sends sample transfers, computes the Hann-windowed spectrum of every due
// frame and checks each bin transfer against it, with random stalls on both
// sides, several hop_period settings and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import wfms_pkg::*;

  localparam int Len = 128;
  localparam int Half = Len / 2;
  localparam int HoldCycles = 3000;
  localparam int WatchLimit = 20000;

  typedef struct {
    logic [BinW-1:0]        idx;
    logic signed [ValW-1:0] val;
    logic                   last;
  } bin_t;

  localparam int QuarterTab [0:32] = '{
    32768, 32729, 32610, 32413, 32138, 31786, 31357, 30853,
    30274, 29622, 28899, 28106, 27245, 26319, 25330, 24279,
    23170, 22006, 20788, 19520, 18205, 16846, 15447, 14010,
    12540, 11039, 9512, 7962, 6393, 4808, 3212, 1608, 0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [HopW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SampleW-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BinW-1:0] bin_index;
  logic signed [ValW-1:0] bin_value;
  logic last_bin;

  windowed_fft_magnitude_spectrum uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .bin_index(bin_index), .bin_value(bin_value), .last_bin(last_bin)
  );

  always #10 clk = ~clk;

  // spectrum predictor state
  int ring [Len];
  int wr_ptr;
  int frame_cnt;
  int hop;

  logic signed [SampleW-1:0] sample_q[$];
  bin_t bins_due[$];
  bit sample_taken;
  int errors;
  int idle_cycles;
  int in_count;
  int out_count;
  bit hold_req;
  int hold_left;

  function automatic int cos_full(int m);
    int q;
    q = m & 127;
    if (q <= 32) return QuarterTab[q];
    if (q <= 64) return -QuarterTab[64 - q];
    if (q <= 96) return -QuarterTab[q - 64];
    return QuarterTab[128 - q];
  endfunction

  function automatic int cos_sat(int m);
    int c;
    c = cos_full(m);
    return (c > 32767) ? 32767 : c;
  endfunction

  function automatic longint rnd15(longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic predict_sample(input logic signed [SampleW-1:0] x);
    int xw [Len];
    int w, s;
    longint acc, sr, si, re, im, v;
    longint unsigned mag;
    bin_t b;
    ring[wr_ptr] = x;
    wr_ptr = (wr_ptr + 1) % Len;
    if (frame_cnt > 1) begin
      frame_cnt--;
      return;
    end
    frame_cnt = hop;
    for (int n = 0; n < Len; n++) begin
      w = (32768 - cos_full(n) + 1) >>> 1;
      if (w > 32767) w = 32767;
      s = ring[(wr_ptr + n) % Len];
      xw[n] = int'(rnd15(longint'(s) * w));
    end
    for (int k = 0; k < Half; k++) begin
      if (k == 0) begin
        acc = 0;
        for (int n = 0; n < Len; n++) acc += xw[n];
        v = (acc > 2097151) ? 2097151 : (acc < -2097152) ? -2097152 : acc;
      end else begin
        sr = 0;
        si = 0;
        for (int n = 0; n < Len; n++) begin
          sr += longint'(xw[n]) * cos_sat((n * k) & 127);
          si += longint'(xw[n]) * cos_sat(((n * k) & 127) + 96);
        end
        re = rnd15(sr);
        im = -rnd15(si);
        mag = int_sqrt(longint'(re * re + im * im));
        v = (mag > 2097151) ? 2097151 : longint'(mag);
      end
      b.idx = BinW'(k);
      b.val = ValW'(v);
      b.last = (k == Half - 1);
      bins_due.push_back(b);
    end
  endtask

  // posedge: transfers on all channels, checking, watchdog
  always @(posedge clk) begin
    bin_t e;
    bit act;
    if (!rst) begin
      act = 1'b0;
      if (cfg_valid && cfg_ready) begin
        hop = cfg_data;
        act = 1'b1;
      end
      if (in_valid && in_ready) begin
        predict_sample(sample);
        sample_taken = 1'b1;
        in_count++;
        act = 1'b1;
      end
      if (out_valid && out_ready) begin
        act = 1'b1;
        out_count++;
        if (bins_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected bin transfer idx=%0d val=%0d last=%0b",
                                     bin_index, bin_value, last_bin);
        end else begin
          e = bins_due.pop_front();
          if (e.idx !== bin_index || e.val !== bin_value || e.last !== last_bin) begin
            errors++;
            if (errors <= 10)
              $display("bin mismatch: exp idx=%0d val=%0d last=%0b, got idx=%0d val=%0d last=%0b",
                       e.idx, e.val, e.last, bin_index, bin_value, last_bin);
          end
        end
      end
      idle_cycles <= act ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    bit quiet;
    quiet = (in_count >= 40 && in_count < 80);
    if (!in_valid || sample_taken) begin
      sample_taken = 1'b0;
      if (!rst && sample_q.size() != 0 && (quiet || $urandom_range(99) >= 25)) begin
        sample <= sample_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // bin receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_count >= 200 && out_count < 400) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 25);
    end
  end

  task automatic wait_drained();
    wait (sample_q.size() == 0 && !in_valid && bins_due.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_hop(input int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= HopW'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample();
    int r;
    r = $urandom_range(9);
    if (r < 6) return SampleW'($urandom);
    if (r < 8) return SampleW'($urandom_range(512)) - 16'sd256;
    return (r == 8) ? 16'sh7fff : 16'sh8000;
  endfunction

  initial begin
    int n_rand;
    for (int i = 0; i < Len; i++) ring[i] = 0;
    wr_ptr = 0;
    frame_cnt = 0;
    hop = HopReset;
    errors = 0;
    idle_cycles = 0;
    in_count = 0;
    out_count = 0;
    hold_req = 0;
    hold_left = 0;
    sample_taken = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset hop; first sample starts a frame, extremes and sign edges
    write_hop(HopReset);
    sample_q = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh7fff,
                 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh5555, 16'shaaaa, 16'sh7fff,
                 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0100, 16'sh8000};
    wait_drained();

    // zero period acts like one; takes effect only at the next reload
    write_hop(0);
    for (int i = 0; i < 14; i++) sample_q.push_back(rand_sample());
    wait_drained();

    write_hop(1);
    for (int i = 0; i < 2; i++) sample_q.push_back(rand_sample());
    wait_drained();

    // random stream, long receiver hold-off at the first frame
    write_hop(37);
    n_rand = 150;
    hold_req = 1'b1;
    for (int i = 0; i < n_rand; i++) sample_q.push_back(rand_sample());
    wait_drained();

    write_hop(65535);
    for (int i = 0; i < 3; i++) sample_q.push_back(rand_sample());
    wait_drained();
    repeat (100) @(posedge clk);

    if (errors == 0 && bins_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ windowed_fft_magnitude_spectrum.f @@
src/wfms_pkg.sv
src/wfms_ram.sv
src/windowed_fft_magnitude_spectrum.sv
tb/tb_top.sv
